>>> hdl/mstt_pkg.sv
// Shared types and constants of the multi-slot timer table.
// Used by mstt_ctrl, mstt_dp and multi_slot_timer_table; depends on nothing.
package mstt_pkg;

	localparam int DEF_NUM_SLOTS = 32;
	localparam int DEF_TIME_BITS = 32;
	localparam int MAX_RESULTS   = 32;

	localparam int FUNC_W   = 2;
	localparam int DATA_W   = 32;
	localparam int PERIOD_W = 31;
	localparam int IDX_W    = 5;
	localparam int SLOT_W   = 5;
	localparam int KIND_W   = 3;
	localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SET   = 2'd0,
		FUNC_KILL  = 2'd1,
		FUNC_CHECK = 2'd2,
		FUNC_SPARE = 2'd3
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_OK   = 3'd0,
		KIND_SET_FAIL = 3'd1,
		KIND_KILLED   = 3'd2,
		KIND_FIRED    = 3'd3,
		KIND_NONE     = 3'd4
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch item fields, rewind scan
		logic kill;        // clear one slot, report it
		logic set_reject;  // negative period: report failure
		logic set_step;    // test one slot for a set
		logic chk_run;     // check scan: issue read, evaluate previous slot
		logic chk_fin;     // check scan: emit closing result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic set_done;    // set found a slot or ran off the table
		logic chk_end;     // last slot evaluated or result room used up
	} status_t;

endpackage

>>> hdl/mstt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mstt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/mstt_ctrl.sv
// Controller state machine of the timer table: sequences set, kill and check items.
// Depends on mstt_pkg; drives the datapath through cmd_t, reads status_t.
module mstt_ctrl
	import mstt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  logic              period_neg,
	input  status_t           status,
	output cmd_t              cmd,
	output logic              busy
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SET   = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					unique case (func)
						FUNC_SET: begin
							if (period_neg) begin
								cmd.set_reject = 1'b1;
							end else begin
								state_d = ST_SET;
							end
						end
						FUNC_KILL: begin
							cmd.kill = 1'b1;
						end
						FUNC_CHECK: begin
							state_d = ST_CHECK;
						end
						default: begin
							// unused code: dropped without a result
						end
					endcase
				end
			end
			ST_SET: begin
				cmd.set_step = 1'b1;
				if (status.set_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				cmd.chk_run = 1'b1;
				if (status.chk_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.chk_fin = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/mstt_dp.sv
// Datapath of the timer table: slot flags, deadline/period RAM, scan counter,
// due compare, reload adder and result register. Depends on mstt_pkg, mstt_ram.
module mstt_dp
	import mstt_pkg::*;
#(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic [DATA_W-1:0]        now,
	input  logic signed [DATA_W-1:0] period,
	input  logic                     repeating,
	input  logic [IDX_W-1:0]         slot_index,
	output status_t                  status,
	output logic                     strobe,
	output logic [KIND_W-1:0]        kind,
	output logic [SLOT_W-1:0]        slot,
	output logic                     last
);

	localparam int DW = (TIME_BITS < DATA_W) ? TIME_BITS : DATA_W;
	localparam int PW = (DW < PERIOD_W) ? DW : PERIOD_W;
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int RW = PW + DW;

	logic [DW-1:0]        now_q;
	logic [PW-1:0]        per_q;
	logic                 rep_in_q;
	logic [CW-1:0]        scan_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] repeat_q;
	logic                 vld_s1;
	logic [SW-1:0]        slot_s1;
	logic [CNT_W-1:0]     fire_cnt_q;
	logic                 pend_q;
	logic [SW-1:0]        pend_slot_q;
	logic                 strobe_q;
	kind_t                kind_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 last_q;

	logic [SW-1:0] set_idx;
	logic          set_free;
	logic          set_last;
	logic          issue;
	logic          eval;
	logic          due;
	logic          kill_hit;
	logic [SW-1:0] kill_idx;
	logic          ram_we;
	logic [SW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [RW-1:0] ram_rdata;
	logic [PW-1:0] rd_per;
	logic [DW-1:0] rd_dl;

	// set: one slot tested per cycle, lowest index first
	assign set_idx  = scan_q[SW-1:0];
	assign set_free = !active_q[set_idx];
	assign set_last = (set_idx == SW'(NUM_SLOTS - 1));

	// check: read slot scan_q now, evaluate it in the next cycle
	assign issue  = cmd.chk_run && (scan_q != CW'(NUM_SLOTS));
	assign eval   = cmd.chk_run && vld_s1;
	assign rd_per = ram_rdata[RW-1:DW];
	assign rd_dl  = ram_rdata[DW-1:0];
	assign due    = eval && active_q[slot_s1] && (rd_dl < now_q);

	assign status.set_done = set_free || set_last;
	assign status.chk_end  = eval && ((slot_s1 == SW'(NUM_SLOTS - 1)) ||
		(due && (fire_cnt_q == CNT_W'(MAX_RESULTS - 1))));

	assign kill_hit = cmd.kill && (32'(slot_index) < NUM_SLOTS);
	assign kill_idx = SW'(slot_index);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = set_idx;
		ram_wdata = {per_q, now_q + DW'(per_q)};
		if (cmd.set_step && set_free) begin
			ram_we = 1'b1;
		end else if (due && repeat_q[slot_s1]) begin
			ram_we    = 1'b1;
			ram_waddr = slot_s1;
			ram_wdata = {rd_per, rd_dl + DW'(rd_per)};
		end
	end

	mstt_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q[SW-1:0]),
		.rdata (ram_rdata)
	);

	// item fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q    <= now[DW-1:0];
			per_q    <= period[PW-1:0];
			rep_in_q <= repeating;
		end
		slot_s1 <= scan_q[SW-1:0];
	end

	// slot flags, scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			repeat_q    <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			fire_cnt_q  <= '0;
			pend_q      <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.capture) begin
				scan_q     <= '0;
				fire_cnt_q <= '0;
				pend_q     <= 1'b0;
			end
			if (issue || (cmd.set_step && !status.set_done)) begin
				scan_q <= scan_q + CW'(1);
			end
			if (cmd.set_step && set_free) begin
				active_q[set_idx] <= 1'b1;
				repeat_q[set_idx] <= rep_in_q;
			end
			if (kill_hit) begin
				active_q[kill_idx] <= 1'b0;
				repeat_q[kill_idx] <= 1'b0;
			end
			if (due) begin
				pend_q      <= 1'b1;
				fire_cnt_q  <= fire_cnt_q + CNT_W'(1);
				if (!repeat_q[slot_s1]) begin
					active_q[slot_s1] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (due) begin
			pend_slot_q <= slot_s1;
		end
	end

	// result register; a fired slot is held back one find so last can be set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.kill || cmd.set_reject || cmd.chk_fin ||
				(cmd.set_step && status.set_done) || (due && pend_q);
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.kill) begin
			kind_q <= KIND_KILLED;
			slot_q <= SLOT_W'(slot_index);
			last_q <= 1'b1;
		end else if (cmd.set_reject) begin
			kind_q <= KIND_SET_FAIL;
			slot_q <= '0;
			last_q <= 1'b1;
		end else if (cmd.set_step) begin
			kind_q <= set_free ? KIND_SET_OK : KIND_SET_FAIL;
			slot_q <= set_free ? SLOT_W'(set_idx) : '0;
			last_q <= 1'b1;
		end else if (cmd.chk_fin) begin
			kind_q <= pend_q ? KIND_FIRED : KIND_NONE;
			slot_q <= pend_q ? SLOT_W'(pend_slot_q) : '0;
			last_q <= 1'b1;
		end else if (due) begin
			kind_q <= KIND_FIRED;
			slot_q <= SLOT_W'(pend_slot_q);
			last_q <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign kind   = kind_q;
	assign slot   = slot_q;
	assign last   = last_q;

`ifndef NO_ASSERTIONS
	a_only_fired_open: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (kind_q != KIND_FIRED)) |-> last_q)
		else $error("non-fired result without last");

	a_fire_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("fired count beyond result room");

	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_step && set_free) |=> active_q[$past(set_idx)])
		else $error("granted slot not active");

	a_last_fired_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (kind_q == KIND_FIRED) && last_q) |-> $past(cmd.chk_fin))
		else $error("closing fired result outside scan end");
`endif

endmodule

>>> hdl/multi_slot_timer_table.sv
// Top level of the multi-slot timer table: controller plus datapath.
// Depends on mstt_pkg, mstt_ctrl, mstt_dp (which holds mstt_ram).
//
// A table of NUM_SLOTS timers. Drive func/now/period/repeating/slot_index and
// pulse start while busy is low; the item is taken on that edge. Results come
// back one per cycle on kind/slot/last, each marked by a one-cycle strobe, and
// must be taken when shown: there is no way to stall them. last flags the final
// result of an item.
//  - kill: one result the cycle after start; busy stays low.
//  - set with negative period: one result the cycle after start, busy low.
//  - set: tests one slot per cycle from slot 0 up and takes the lowest free slot
//    (failing when the table is full); the result shows in the first cycle with
//    busy low again.
//  - check: walks every slot through the deadline RAM (one read per cycle,
//    registered read data) and then closes out; fired results trickle out
//    during the walk, the final one right after. At most 32 fired results per
//    check; a walk that reaches that count stops.
//  - func 3: ignored, no result.
// Deadlines wrap at TIME_BITS (capped at 32) and "due" is an unsigned
// deadline < now. Reset clears all slots at once; no clearing pass is needed.
module multi_slot_timer_table
	import mstt_pkg::*;
#(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [FUNC_W-1:0]        func,
	input  logic [DATA_W-1:0]        now,
	input  logic signed [DATA_W-1:0] period,
	input  logic                     repeating,
	input  logic [IDX_W-1:0]         slot_index,
	output logic                     strobe,
	output logic [KIND_W-1:0]        kind,
	output logic [SLOT_W-1:0]        slot,
	output logic                     last
);

	cmd_t    cmd;
	status_t status;

	// sequencing of set / kill / check
	mstt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.period_neg (period[DATA_W-1]),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy)
	);

	// slot state, deadline RAM and result register
	mstt_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.now        (now),
		.period     (period),
		.repeating  (repeating),
		.slot_index (slot_index),
		.status     (status),
		.strobe     (strobe),
		.kind       (kind),
		.slot       (slot),
		.last       (last)
	);

endmodule
